// ===== hw/rtl/dual_reader_overwrite_ring_assert.svh =====
// Assertion macros for the dual reader overwrite ring.
// Used by the top level; expects signals clk and arst_n in the calling scope.
`ifndef DUAL_READER_OVERWRITE_RING_ASSERT_SVH
`define DUAL_READER_OVERWRITE_RING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/drr_pkg.sv =====
// Shared types and codes for the dual reader overwrite ring.
// No dependencies.
`default_nettype none

package drr_pkg;

	localparam int TIME_W  = 32;
	localparam int FRAME_W = 64;
	localparam int PLOT_W  = 7;
	localparam int MV_W    = 16;
	localparam int FILL_W  = 7;
	localparam int LIMIT_W = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_DRAIN  = 2'd1,
		REQ_PLOT   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_ARCHIVE = 2'd0,
		KIND_PLOT    = 2'd1,
		KIND_ALERT   = 2'd2,
		KIND_DROP    = 2'd3
	} kind_t;

	// One stored ring entry.
	typedef struct packed {
		logic [TIME_W-1:0]  time_stamp;
		logic [FRAME_W-1:0] frame;
	} entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/drr_store.sv =====
// Frame store of the ring: one write port, one registered read port.
// Depends on drr_pkg (entry_t).
`default_nettype none

module drr_store
	import drr_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_reader_overwrite_ring.sv =====
// Top level of the dual reader overwrite ring: sequencer, pointers, output register.
// Depends on drr_pkg, drr_store and dual_reader_overwrite_ring_assert.svh.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser req_type, tdata time/frame/plot_count
//  m_*     | out | m_tvalid/m_tready  | tuser kind, tlast last, tdata see port
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data = no_data_limit
//
// Flow: one request at a time through a single store read port. An append
// passes eval and write, then drop when full. A drain or plot read passes eval,
// then read and load per frame emitted (read issue, then output load); an empty
// plot read passes eval, then alert on reaching the limit. Output stalls hold drop,
// alert and load. Reset: pointers and counts clear at once, limit to LIMIT_RESET;
// the store has no reset and needs no clearing pass. cfg_ready stays high.
`default_nettype none

`include "dual_reader_overwrite_ring_assert.svh"

module dual_reader_overwrite_ring
	import drr_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int FRAME_BYTES = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] time_stamp, [95:32] frame_data, [102:96] plot_count, [103] zero
	input  wire logic [103:0] s_tdata,
	// [1:0] req_type
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] out_time, [95:32] out_frame, [111:96] millivolts,
	// [118:112] fill_level, [119] zero
	output logic [119:0]      m_tdata,
	// [1:0] kind
	output logic [1:0]        m_tuser,
	output logic              m_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [FRAME_W-1:0] FRAME_MASK = {FRAME_W{1'b1}} >> (FRAME_W - 8 * FRAME_BYTES);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EVAL  = 7'b0000010,
		S_WRITE = 7'b0000100,
		S_DROP  = 7'b0001000,
		S_ALERT = 7'b0010000,
		S_READ  = 7'b0100000,
		S_LOAD  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   wp_q, ap_q, pp_q;
	logic [CNT_W-1:0]   pend_q;
	logic [CNT_W-1:0]   rem_q;
	logic [LIMIT_W-1:0] er_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               is_plot_q;
	logic               m_tvalid_q;

	// Latched request payload.
	req_t               req_q;
	logic [TIME_W-1:0]  ts_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PLOT_W-1:0]  want_q;

	logic [119:0]       m_tdata_q;
	logic [1:0]         m_tuser_q;
	logic               m_tlast_q;

	entry_t             wr_entry, rd_entry;
	logic               st_we, st_re;
	logic [PTR_W-1:0]   st_raddr;

	logic               out_free, out_load;
	logic [PTR_W:0]     plot_avail;
	logic [CNT_W-1:0]   plot_n;
	logic [LIMIT_W-1:0] er_inc;

	kind_t              kind_d;
	logic [TIME_W-1:0]  time_d;
	logic [FRAME_W-1:0] frame_d;
	logic [MV_W-1:0]    mv_d;
	logic               last_d;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	// Output register is free when empty or being taken this cycle.
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free &&
		(state_q == S_DROP || state_q == S_ALERT || state_q == S_LOAD);

	// Frames the plot reader can see; equal pointers mean empty.
	always_comb begin
		if (wp_q >= pp_q) begin
			plot_avail = {1'b0, wp_q} - {1'b0, pp_q};
		end else begin
			plot_avail = {1'b0, wp_q} + (PTR_W + 1)'(DEPTH) - {1'b0, pp_q};
		end
		if (want_q < PLOT_W'(plot_avail)) begin
			plot_n = CNT_W'(want_q);
		end else begin
			plot_n = CNT_W'(plot_avail);
		end
	end

	assign er_inc = er_q + 1'b1;

	// Store ports: read old entry before an append, or the next frame to emit.
	assign wr_entry.time_stamp = ts_q;
	assign wr_entry.frame      = frame_q;
	assign st_we    = (state_q == S_WRITE);
	assign st_re    = (state_q == S_EVAL && req_q == REQ_APPEND) || (state_q == S_READ);
	assign st_raddr = (state_q == S_READ) ? (is_plot_q ? pp_q : ap_q) : wp_q;

	drr_store #(
		.DEPTH (DEPTH),
		.AW    (PTR_W)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (wp_q),
		.wdata (wr_entry),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (rd_entry)
	);

	// Result fields for the transaction being loaded.
	always_comb begin
		kind_d  = KIND_ARCHIVE;
		time_d  = rd_entry.time_stamp;
		frame_d = rd_entry.frame;
		mv_d    = '0;
		last_d  = 1'b1;
		case (state_q)
			S_DROP: begin
				kind_d = KIND_DROP;
			end
			S_ALERT: begin
				kind_d  = KIND_ALERT;
				time_d  = '0;
				frame_d = '0;
			end
			S_LOAD: begin
				last_d = (rem_q == CNT_W'(1));
				if (is_plot_q) begin
					kind_d  = KIND_PLOT;
					frame_d = '0;
					mv_d    = rd_entry.frame[31:16];
				end
			end
			default: begin
				kind_d = KIND_ARCHIVE;
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wp_q       <= '0;
			ap_q       <= '0;
			pp_q       <= '0;
			pend_q     <= '0;
			rem_q      <= '0;
			er_q       <= '0;
			limit_q    <= LIMIT_RESET;
			is_plot_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			// Set the valid on a load; drop it once taken.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					case (req_q)
						REQ_APPEND: begin
							state_q <= S_WRITE;
						end
						REQ_DRAIN: begin
							if (pend_q != '0) begin
								rem_q     <= pend_q;
								pend_q    <= '0;
								is_plot_q <= 1'b0;
								state_q   <= S_READ;
							end else begin
								state_q <= S_IDLE;
							end
						end
						REQ_PLOT: begin
							if (plot_n != '0) begin
								rem_q     <= plot_n;
								is_plot_q <= 1'b1;
								state_q   <= S_READ;
							end else if (er_inc == limit_q) begin
								er_q    <= '0;
								state_q <= S_ALERT;
							end else begin
								er_q    <= er_inc;
								state_q <= S_IDLE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_WRITE: begin
					wp_q <= next_slot(wp_q);
					if (pend_q < CNT_W'(DEPTH)) begin
						pend_q  <= pend_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						// Full: the oldest frame is gone for both readers.
						ap_q    <= next_slot(ap_q);
						pp_q    <= next_slot(pp_q);
						state_q <= S_DROP;
					end
				end
				S_DROP, S_ALERT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						rem_q <= rem_q - 1'b1;
						if (is_plot_q) begin
							pp_q <= next_slot(pp_q);
						end else begin
							ap_q <= next_slot(ap_q);
						end
						state_q <= (rem_q == CNT_W'(1)) ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request latch and output data.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q   <= req_t'(s_tuser);
			ts_q    <= s_tdata[31:0];
			frame_q <= s_tdata[95:32] & FRAME_MASK;
			want_q  <= s_tdata[102:96];
		end
		if (out_load) begin
			m_tdata_q <= {1'b0, FILL_W'(pend_q), mv_d, frame_d, time_d};
			m_tuser_q <= kind_d;
			m_tlast_q <= last_d;
		end
	end

	`DRR_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= CNT_W'(DEPTH), "fill count above depth")
	`DRR_ASSERT_NOW(a_load_free, out_load, out_free, "output loaded while stalled")
	`DRR_ASSERT_NOW(a_drop_full, out_load && kind_d == KIND_DROP, pend_q == CNT_W'(DEPTH), "drop without full ring")
	`DRR_ASSERT_NOW(a_read_rem, state_q == S_READ, rem_q != '0, "frame read with none left")
	`DRR_ASSERT_NEXT(a_write_adv, state_q == S_WRITE, wp_q == next_slot($past(wp_q)), "write pointer did not advance")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for dual_reader_overwrite_ring: drives requests and limit writes,
// mirrors the ring state to predict every output transaction and checks them in order.
// Depends on drr_pkg and the RTL of dual_reader_overwrite_ring.
module tb;
	import drr_pkg::*;

	localparam int RING_DEPTH    = 64;
	localparam int HALF_PERIOD   = 5;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		kind_t              kind;
		logic [TIME_W-1:0]  stamp;
		logic [FRAME_W-1:0] frame;
		logic [MV_W-1:0]    mv;
		logic [FILL_W-1:0]  fill;
		logic               last;
	} ring_result_t;

	// Mirror of the ring: stores, pointers, counters and the output transactions still due.
	class ring_mirror;
		logic [TIME_W-1:0]  stamp_mem [RING_DEPTH];
		logic [FRAME_W-1:0] frame_mem [RING_DEPTH];
		int                 wr_slot;
		int                 archive_slot;
		int                 plot_slot;
		int                 backlog;
		logic [LIMIT_W-1:0] miss_count;
		logic [LIMIT_W-1:0] alert_limit;
		ring_result_t       due [$];
		int                 errors;
		int                 requests;
		int                 ignored;
		int                 archived;
		int                 samples;
		int                 alerts;
		int                 drops;

		function new();
			foreach (stamp_mem[i]) begin
				stamp_mem[i] = '0;
				frame_mem[i] = '0;
			end
			wr_slot      = 0;
			archive_slot = 0;
			plot_slot    = 0;
			backlog      = 0;
			miss_count   = '0;
			alert_limit  = LIMIT_RESET;
			errors       = 0;
			requests     = 0;
			ignored      = 0;
			archived     = 0;
			samples      = 0;
			alerts       = 0;
			drops        = 0;
		endfunction

		function int advance(int p);
			return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
		endfunction

		function void queue_result(kind_t k, logic [TIME_W-1:0] stamp,
				logic [FRAME_W-1:0] frame, logic [MV_W-1:0] mv, logic last);
			ring_result_t r;
			r.kind  = k;
			r.stamp = stamp;
			r.frame = frame;
			r.mv    = mv;
			r.fill  = backlog[FILL_W-1:0];
			r.last  = last;
			due.push_back(r);
		endfunction

		// Advance the mirror by one accepted request and queue what it must produce.
		function void absorb_request(req_t req, logic [TIME_W-1:0] ts,
				logic [FRAME_W-1:0] fr, logic [PLOT_W-1:0] cnt);
			logic [TIME_W-1:0]  old_stamp;
			logic [FRAME_W-1:0] old_frame;
			int                 avail;
			int                 p;
			case (req)
				REQ_APPEND: begin
					requests++;
					old_stamp = stamp_mem[wr_slot];
					old_frame = frame_mem[wr_slot];
					stamp_mem[wr_slot] = ts;
					frame_mem[wr_slot] = fr;
					wr_slot = advance(wr_slot);
					if (backlog < RING_DEPTH) begin
						backlog++;
					end else begin
						// Full: the oldest frame is gone, both readers skip past it.
						plot_slot    = advance(plot_slot);
						archive_slot = advance(archive_slot);
						queue_result(KIND_DROP, old_stamp, old_frame, '0, 1'b1);
						drops++;
					end
				end
				REQ_DRAIN: begin
					requests++;
					avail   = backlog;
					backlog = 0;
					p       = archive_slot;
					for (int i = 0; i < avail; i++) begin
						queue_result(KIND_ARCHIVE, stamp_mem[p], frame_mem[p], '0, i + 1 == avail);
						p = advance(p);
					end
					archive_slot = p;
					archived += avail;
				end
				REQ_PLOT: begin
					requests++;
					// Equal pointers read as empty, even with the ring full.
					avail = (wr_slot + RING_DEPTH - plot_slot) % RING_DEPTH;
					if (cnt < avail) avail = int'(cnt);
					if (avail == 0) begin
						miss_count = miss_count + 1'b1;
						if (miss_count == alert_limit) begin
							miss_count = '0;
							queue_result(KIND_ALERT, '0, '0, '0, 1'b1);
							alerts++;
						end
					end else begin
						p = plot_slot;
						for (int i = 0; i < avail; i++) begin
							queue_result(KIND_PLOT, stamp_mem[p], '0, frame_mem[p][31:16],
								i + 1 == avail);
							p = advance(p);
						end
						plot_slot = p;
						samples += avail;
					end
				end
				default: begin
					ignored++;
				end
			endcase
		endfunction

		function string show(ring_result_t r);
			return $sformatf("kind=%0d time=%h frame=%h mv=%h fill=%0d last=%b",
				r.kind, r.stamp, r.frame, r.mv, r.fill, r.last);
		endfunction

		// Compare one output transaction against the oldest one due.
		function void match_output(ring_result_t got);
			ring_result_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) $display("tb: output with none due: %s", show(got));
				return;
			end
			want = due.pop_front();
			if (got.kind !== want.kind || got.stamp !== want.stamp || got.frame !== want.frame
					|| got.mv !== want.mv || got.fill !== want.fill || got.last !== want.last) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("tb: mismatch, expected %s", show(want));
					$display("tb:           actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata   = '0;
	logic [1:0]   s_tuser   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [119:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_data  = '0;

	bit           tx_idle      = 1'b1;
	bit           rx_idle      = 1'b1;
	bit           hold_request = 1'b0;
	int           quiet_cycles = 0;
	int           limit_writes = 0;
	ring_mirror   mirror;
	ring_result_t observed;

	dual_reader_overwrite_ring dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [FRAME_W-1:0] rand_frame();
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			observed.kind  = kind_t'(m_tuser);
			observed.stamp = m_tdata[31:0];
			observed.frame = m_tdata[95:32];
			observed.mv    = m_tdata[111:96];
			observed.fill  = m_tdata[118:112];
			observed.last  = m_tlast;
			mirror.match_output(observed);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: no transaction for %0d cycles, %0d outputs still due",
				STALL_LIMIT, mirror.due.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// Output side: random back-pressure, plus one long hold when asked.
	initial begin : receiver
		int stall_left;
		bit hold_taken;
		stall_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle && $urandom_range(0, 99) < 20) stall_left = pick_gap();
			end
		end
	end

	// Offer one request after an optional gap; hold it until accepted.
	task automatic send(req_t req, logic [TIME_W-1:0] ts, logic [FRAME_W-1:0] fr,
			logic [PLOT_W-1:0] cnt);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {1'b0, cnt, fr, ts};
		do @(posedge clk); while (!s_tready);
		mirror.absorb_request(req, ts, fr, cnt);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror.alert_limit = value;
		limit_writes++;
	endtask

	// Drop valid, wait for every due output, then let a silent append finish.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (mirror.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int quota, bit open_with_burst);
		int                issued;
		int                r;
		int                len;
		logic [PLOT_W-1:0] cnt;
		issued = 0;
		if (open_with_burst) begin
			// Run past full: drops, then a plot read that must see the ring as empty.
			repeat (RING_DEPTH + 6)
				send(REQ_APPEND, $urandom, rand_frame(), PLOT_W'($urandom_range(0, 64)));
			send(REQ_PLOT, $urandom, rand_frame(), 7'd64);
			issued = RING_DEPTH + 7;
		end
		while (issued < quota) begin
			r = $urandom_range(0, 99);
			if (r < 4) len = $urandom_range(RING_DEPTH, RING_DEPTH + 8);
			else if (r < 55) len = $urandom_range(1, 6);
			else len = 0;
			if (len > 0) begin
				repeat (len)
					send(REQ_APPEND, $urandom, rand_frame(), PLOT_W'($urandom_range(0, 64)));
				issued += len;
			end else if (r < 70) begin
				send(REQ_DRAIN, $urandom, rand_frame(), PLOT_W'($urandom_range(0, 64)));
				issued++;
			end else if (r < 97) begin
				if (r < 80) cnt = PLOT_W'($urandom_range(1, 8));
				else if (r < 88) cnt = PLOT_W'($urandom_range(9, 63));
				else if (r < 92) cnt = 7'd64;
				else cnt = 7'd0;
				send(REQ_PLOT, $urandom, rand_frame(), cnt);
				issued++;
			end else begin
				// Unused code: the block should swallow it.
				send(REQ_NONE, $urandom, rand_frame(), PLOT_W'($urandom_range(0, 64)));
			end
		end
		quiesce();
	endtask

	initial begin : stimulus
		mirror = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset limit.
		send(REQ_DRAIN, '0, '0, 7'd0);
		send(REQ_PLOT, '0, '0, 7'd5);
		send(REQ_PLOT, '0, '0, 7'd0);
		send(REQ_NONE, '1, '1, 7'd64);
		send(REQ_APPEND, '0, '0, 7'd0);
		send(REQ_APPEND, '1, '1, 7'd64);
		send(REQ_APPEND, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
		send(REQ_APPEND, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 7'd0);
		send(REQ_PLOT, '0, '0, 7'd0);
		send(REQ_PLOT, '0, '0, 7'd1);
		send(REQ_PLOT, '0, '0, 7'd64);
		send(REQ_PLOT, '0, '0, 7'd64);
		send(REQ_DRAIN, '1, '1, 7'd64);
		send(REQ_DRAIN, '0, '0, 7'd0);
		send(REQ_NONE, '0, '0, 7'd0);
		// Six more empty reads bring the count to the reset limit: one alert.
		repeat (6) send(REQ_PLOT, $urandom, rand_frame(), 7'd64);
		send(REQ_APPEND, $urandom, rand_frame(), 7'd0);
		send(REQ_PLOT, '0, '0, 7'd64);
		send(REQ_DRAIN, '0, '0, 7'd0);
		quiesce();

		// Limit 1: every empty plot read alerts.
		write_limit(8'd1);
		run_random(80, 1'b1);

		// Limit 255, opening with a long output hold while requests keep coming.
		write_limit(8'd255);
		hold_request = 1'b1;
		repeat (6) send(REQ_APPEND, $urandom, rand_frame(), 7'd0);
		send(REQ_DRAIN, '0, '0, 7'd0);
		send(REQ_PLOT, '0, '0, 7'd64);
		run_random(30, 1'b0);

		// Set the limit below the current empty-read count: the alert waits for wrap-around.
		tx_idle = 1'b0;
		while (mirror.miss_count < 2) send(REQ_PLOT, $urandom, rand_frame(), 7'd0);
		quiesce();
		write_limit(mirror.miss_count - 1'b1);
		repeat (255) send(REQ_PLOT, $urandom, rand_frame(), 7'd0);
		quiesce();

		// A stretch with no idling on either side.
		rx_idle = 1'b0;
		write_limit(LIMIT_W'($urandom_range(2, 254)));
		run_random(30, 1'b0);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_limit(LIMIT_RESET);
		run_random(30, 1'b0);

		repeat (20) @(posedge clk);
		$display("tb: %0d requests (%0d ignored), %0d limit writes",
			mirror.requests, mirror.ignored, limit_writes);
		$display("tb: %0d archive frames, %0d plot samples, %0d alerts, %0d drop notices checked",
			mirror.archived, mirror.samples, mirror.alerts, mirror.drops);
		if (mirror.errors == 0 && mirror.due.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/drr_pkg.sv
hw/rtl/drr_store.sv
hw/rtl/dual_reader_overwrite_ring.sv
sim/tb.sv
